FILE: hdl/lkrl_pkg.sv
// Shared widths for the LRU key recency list.
package lkrl_pkg;

   // Fixed field widths of the request and response transactions
   localparam int KEY_W  = 16;
   localparam int RANK_W = 4;
   localparam int OCC_W  = 5;

endpackage

FILE: hdl/lru_key_recency_list.sv
// Top level of the LRU key recency list: chain of key cells plus response register.
//
//   channel | direction | ports                                  | payload
//   req     | in        | req_valid, req_stall (out)             | req_access_key
//   rsp     | out       | rsp_valid, rsp_stall (in)              | rsp_was_hit, rsp_hit_rank,
//           |           |                                        | rsp_did_evict, rsp_evicted_key,
//           |           |                                        | rsp_occupancy
//
// One request is taken per cycle while req_stall is low; its response appears in the next cycle.
// The compare runs across all cells at once; the match-seen ripple through the
// chain of CAPACITY cells sets the longest path.
// Reset empties the list (count to zero); stored keys are not cleared.
// req_stall is high only while a response is held and rsp_stall is high.
module lru_key_recency_list #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lkrl_pkg::KEY_W-1:0]         req_access_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_was_hit,
   output logic [lkrl_pkg::RANK_W-1:0]        rsp_hit_rank,
   output logic                               rsp_did_evict,
   output logic [lkrl_pkg::KEY_W-1:0]         rsp_evicted_key,
   output logic [lkrl_pkg::OCC_W-1:0]         rsp_occupancy
);

   localparam int KW = (KEY_BITS < lkrl_pkg::KEY_W) ? KEY_BITS : lkrl_pkg::KEY_W;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(CAPACITY);

   logic                accept;
   logic [KW-1:0]       key;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                full;
   logic                hit;
   logic                evict;
   logic [RW-1:0]       rank;
   logic [CAPACITY-1:0] match;
   logic [CAPACITY:0]   seen;
   logic [KW-1:0]       chain_key [CAPACITY+1];

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       was_hit_ff;
   logic [lkrl_pkg::RANK_W-1:0] hit_rank_ff;
   logic                       did_evict_ff;
   logic [lkrl_pkg::KEY_W-1:0] evicted_key_ff;
   logic [lkrl_pkg::OCC_W-1:0] occupancy_ff;

   // Handshake: hold off requests only while a response is stuck
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign key          = req_access_key[KW-1:0];
   assign chain_key[0] = key;
   assign seen[0]      = 1'b0;

   // Row of cells; slot 0 is the most recent key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lkrl_cell #(
         .KW    (KW),
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .accept     (accept),
         .count      (count_ff),
         .access_key (key),
         .key_prev   (chain_key[i]),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .match      (match[i]),
         .key_out    (chain_key[i+1])
      );
   end

   // Keys are distinct, so at most one cell matches: OR its index together
   always_comb begin
      rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            rank = rank | RW'(i);
         end
      end
   end

   assign hit   = seen[CAPACITY];
   assign full  = count_ff == CW'(CAPACITY);
   assign evict = !hit && full;

   // Occupancy grows on a miss with room left
   always_comb begin
      count_in = count_ff;
      if (accept && !hit && !full) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response register
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         was_hit_ff     <= hit;
         hit_rank_ff    <= hit ? lkrl_pkg::RANK_W'(rank) : '0;
         did_evict_ff   <= evict;
         evicted_key_ff <= evict ? lkrl_pkg::KEY_W'(chain_key[CAPACITY]) : '0;
         occupancy_ff   <= lkrl_pkg::OCC_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_was_hit     = was_hit_ff;
   assign rsp_hit_rank    = hit_rank_ff;
   assign rsp_did_evict   = did_evict_ff;
   assign rsp_evicted_key = evicted_key_ff;
   assign rsp_occupancy   = occupancy_ff;

endmodule

FILE: hdl/lkrl_cell.sv
// One slot of the recency chain: holds a key, compares it, shifts from its neighbor.
module lkrl_cell #(
   parameter int KW    = 16,
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          accept,     // a request transaction enters this cycle
   input  logic [CW-1:0] count,      // keys stored before this transaction
   input  logic [KW-1:0] access_key,
   input  logic [KW-1:0] key_prev,   // key of the more recent neighbor
   input  logic          seen_in,    // a match sits in a more recent slot
   output logic          seen_out,
   output logic          match,
   output logic [KW-1:0] key_out
);

   logic [KW-1:0] key_ff;
   logic [KW-1:0] key_in;
   logic          occupied;
   logic          shift;

   // Slot holds a live key only below the current count
   assign occupied = CW'(INDEX) < count;
   assign match    = occupied && (key_ff == access_key);
   assign seen_out = seen_in | match;

   // Every slot up to and including the hit moves back by one; on a miss every slot does
   assign shift  = accept && !seen_in;
   assign key_in = shift ? key_prev : key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;

endmodule

FILE: hdl/lkrl_checker.sv
// Port-level checks for the LRU key recency list, bound to the top level.
module lkrl_checker #(
   parameter int CAPACITY = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_was_hit,
   input logic [lkrl_pkg::RANK_W-1:0]  rsp_hit_rank,
   input logic                         rsp_did_evict,
   input logic [lkrl_pkg::KEY_W-1:0]   rsp_evicted_key,
   input logic [lkrl_pkg::OCC_W-1:0]   rsp_occupancy
);

   // A held response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every accepted request yields a response in the next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // A miss reports rank zero
   a_miss_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_hit |-> rsp_hit_rank == '0)
      else $error("nonzero rank on a miss");

   // Eviction only on a miss with the list full
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_did_evict |->
         !rsp_was_hit && rsp_occupancy == lkrl_pkg::OCC_W'(CAPACITY))
      else $error("eviction without a full list");

   // No eviction means the evicted key reads zero
   a_evict_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_did_evict |-> rsp_evicted_key == '0)
      else $error("evicted key set without an eviction");

endmodule

bind lru_key_recency_list lkrl_checker #(.CAPACITY(CAPACITY)) u_lkrl_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the LRU key recency list.
`timescale 1ns / 100ps

module tb;

   localparam int CAPACITY     = 16;
   localparam int KEY_BITS     = 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam bit [lkrl_pkg::KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= lkrl_pkg::KEY_W) ? {lkrl_pkg::KEY_W{1'b1}} :
      ((lkrl_pkg::KEY_W'(1) << KEY_BITS) - lkrl_pkg::KEY_W'(1));

   typedef struct packed {
      logic                        was_hit;
      logic [lkrl_pkg::RANK_W-1:0] hit_rank;
      logic                        did_evict;
      logic [lkrl_pkg::KEY_W-1:0]  evicted_key;
      logic [lkrl_pkg::OCC_W-1:0]  occupancy;
   } lru_rsp_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_BLOCKS, STALL_HEAVY} stall_mode_type;

   // Recency order mirror: predicts each access response and checks the DUT against it
   class recency_tracker_type;
      bit [lkrl_pkg::KEY_W-1:0] order [CAPACITY];
      int unsigned    used = 0;
      lru_rsp_type    pending_rsp [$];
      int unsigned    errors = 0;

      function void note_access(bit [lkrl_pkg::KEY_W-1:0] raw_key);
         bit [lkrl_pkg::KEY_W-1:0] key;
         bit             hit;
         int unsigned    rank;
         int unsigned    last;
         lru_rsp_type    exp_rsp;
         key  = raw_key & KEY_MASK;
         hit  = 1'b0;
         rank = 0;
         exp_rsp = '0;
         for (int i = 0; i < used; i++) begin
            if (!hit && order[i] == key) begin
               hit  = 1'b1;
               rank = i;
            end
         end
         if (hit) begin
            last = rank;
         end else if (used >= CAPACITY) begin
            exp_rsp.did_evict   = 1'b1;
            exp_rsp.evicted_key = order[CAPACITY-1];
            last = CAPACITY - 1;
         end else begin
            last = used;
            used++;
         end
         // shift the keys in front of the slot back by one, new key to the front
         for (int i = last; i > 0; i--)
            order[i] = order[i-1];
         order[0] = key;
         exp_rsp.was_hit   = hit;
         exp_rsp.hit_rank  = hit ? lkrl_pkg::RANK_W'(rank) : '0;
         exp_rsp.occupancy = lkrl_pkg::OCC_W'(used);
         pending_rsp.push_back(exp_rsp);
      endfunction

      function void check_response(lru_rsp_type got);
         lru_rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            $error("response with no access outstanding");
            errors++;
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got.was_hit !== exp_rsp.was_hit) begin
            $error("was_hit: expected %0h, actual %0h", exp_rsp.was_hit, got.was_hit);
            errors++;
         end
         if (got.hit_rank !== exp_rsp.hit_rank) begin
            $error("hit_rank: expected %0h, actual %0h", exp_rsp.hit_rank, got.hit_rank);
            errors++;
         end
         if (got.did_evict !== exp_rsp.did_evict) begin
            $error("did_evict: expected %0h, actual %0h", exp_rsp.did_evict, got.did_evict);
            errors++;
         end
         if (got.evicted_key !== exp_rsp.evicted_key) begin
            $error("evicted_key: expected %0h, actual %0h",
                   exp_rsp.evicted_key, got.evicted_key);
            errors++;
         end
         if (got.occupancy !== exp_rsp.occupancy) begin
            $error("occupancy: expected %0h, actual %0h", exp_rsp.occupancy, got.occupancy);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_rsp.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [lkrl_pkg::KEY_W-1:0]  req_access_key;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_was_hit;
   logic [lkrl_pkg::RANK_W-1:0] rsp_hit_rank;
   logic                        rsp_did_evict;
   logic [lkrl_pkg::KEY_W-1:0]  rsp_evicted_key;
   logic [lkrl_pkg::OCC_W-1:0]  rsp_occupancy;

   recency_tracker_type      tracker = new;
   int unsigned              cycles = 0;
   int unsigned              burst_left = 0;
   bit [lkrl_pkg::KEY_W-1:0] key_pool [32];
   int unsigned              pool_size = 8;

   lru_key_recency_list #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_access_key  (req_access_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_was_hit     (rsp_was_hit),
      .rsp_hit_rank    (rsp_hit_rank),
      .rsp_did_evict   (rsp_did_evict),
      .rsp_evicted_key (rsp_evicted_key),
      .rsp_occupancy   (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver stall pattern: picks a random mode and run length, and switches again when the run ends
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 9) < 3);
         STALL_BLOCKS: rsp_stall <= ((stall_left % 16) < 10);
         default:      rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Handshake monitor: sample at the falling edge, act at the next rising edge
   logic                       req_take = 1'b0;
   logic                       rsp_take = 1'b0;
   logic [lkrl_pkg::KEY_W-1:0] req_key_s;
   lru_rsp_type                rsp_s;
   always @(negedge clock) begin
      req_take  = !reset && req_valid && !req_stall;
      req_key_s = req_access_key;
      rsp_take  = !reset && rsp_valid && !rsp_stall;
      rsp_s     = '{rsp_was_hit, rsp_hit_rank, rsp_did_evict, rsp_evicted_key, rsp_occupancy};
   end

   always @(posedge clock) begin
      if (req_take)
         tracker.note_access(req_key_s);
      if (rsp_take)
         tracker.check_response(rsp_s);
   end

   // Drive one access; returns at the edge where it is taken
   task automatic send_access(input bit [lkrl_pkg::KEY_W-1:0] key);
      bit taken;
      if (burst_left == 0) begin
         int unsigned gap;
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_access_key <= key;
      do begin
         @(negedge clock);
         taken = req_valid && !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Hold off the sender until every outstanding response is back;
   // the first edge lets the monitor log the last accepted transaction
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.outstanding() > 0)
         @(posedge clock);
   endtask

   function automatic void refill_pool();
      pool_size = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15) : $urandom_range(17, 32);
      foreach (key_pool[i])
         key_pool[i] = lkrl_pkg::KEY_W'($urandom());
   endfunction

   // Mostly keys from a small working set so hits and evictions both occur
   function automatic bit [lkrl_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, pool_size - 1)];
      return lkrl_pkg::KEY_W'($urandom());
   endfunction

   initial begin
      bit [lkrl_pkg::KEY_W-1:0] directed [$];
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_access_key <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero and all-ones keys, hit at front, fill, oldest hit, evictions
      directed = '{16'h0000, 16'h0000, 16'hFFFF};
      for (int k = 1; k <= 14; k++)
         directed.push_back(lkrl_pkg::KEY_W'(k));
      directed.push_back(16'h0000);   // hit at the last rank
      directed.push_back(16'h8000);   // full miss, evicts the all-ones key
      directed.push_back(16'h8000);   // hit at the front
      directed.push_back(16'h0007);   // hit in the middle
      directed.push_back(16'h5555);
      directed.push_back(16'hAAAA);
      foreach (directed[i])
         send_access(directed[i]);
      drain();

      // Random accesses over changing working sets
      refill_pool();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 199)
            refill_pool();
         if (n == RANDOM_ITEMS / 2)
            drain();
         send_access(pick_key());
      end
      drain();
      repeat (10) @(posedge clock);

      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
